// ----- src/qvr_pkg.sv -----
// Shared types, constants and a width helper for the quaternion vector rotator.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

  localparam int QVR_FRAC_BITS = 14;
  localparam int QVR_VEC_WIDTH = 16;
  localparam int QUAT_WIDTH    = 16;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;
  localparam logic signed [QUAT_WIDTH-1:0] QUAT_V_RESET = 16'sd0;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } qvr_reg_t;

  // register enables for the two stages of one quaternion product
  typedef struct packed {
    logic mul;
    logic sum;
  } qvr_en_t;

  // width of the intermediate quaternion p = q * (0, v) after its shift
  function automatic int qvr_p_width(input int vw, input int fb);
    if (vw + QUAT_WIDTH + 2 > fb + 2) begin
      return vw + QUAT_WIDTH + 2 - fb;
    end
    return 2;
  endfunction

endpackage
`default_nettype wire

// ----- src/qvr_prod1.sv -----
// First quaternion product p = q * (0, v): multiply stage, then sum and shift stage.
`timescale 1ns / 1ps
`default_nettype none
module qvr_prod1 #(
  parameter int VEC_WIDTH = qvr_pkg::QVR_VEC_WIDTH,
  parameter int FRAC_BITS = qvr_pkg::QVR_FRAC_BITS,
  parameter int P_WIDTH   = qvr_pkg::qvr_p_width(VEC_WIDTH, FRAC_BITS)
) (
  input  wire                                       clk,
  input  wire qvr_pkg::qvr_en_t                     en,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qs,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qa,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qb,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qc,
  input  wire logic signed [VEC_WIDTH-1:0]          vx,
  input  wire logic signed [VEC_WIDTH-1:0]          vy,
  input  wire logic signed [VEC_WIDTH-1:0]          vz,
  output logic signed [P_WIDTH-1:0]                 pw_r,
  output logic signed [P_WIDTH-1:0]                 px_r,
  output logic signed [P_WIDTH-1:0]                 py_r,
  output logic signed [P_WIDTH-1:0]                 pz_r
);
  import qvr_pkg::*;

  localparam int MW = QUAT_WIDTH + VEC_WIDTH;
  localparam int SW = MW + 2;

  logic signed [MW-1:0] prod_r [12];
  logic signed [MW-1:0] prod_nxt [12];
  logic signed [SW-1:0] ext [12];
  logic signed [SW-1:0] sum_w, sum_x, sum_y, sum_z;
  logic signed [SW-1:0] sh_w, sh_x, sh_y, sh_z;

  always_comb begin
    prod_nxt[0]  = qa * vx;
    prod_nxt[1]  = qb * vy;
    prod_nxt[2]  = qc * vz;
    prod_nxt[3]  = qb * vz;
    prod_nxt[4]  = qc * vy;
    prod_nxt[5]  = qs * vx;
    prod_nxt[6]  = qc * vx;
    prod_nxt[7]  = qa * vz;
    prod_nxt[8]  = qs * vy;
    prod_nxt[9]  = qa * vy;
    prod_nxt[10] = qb * vx;
    prod_nxt[11] = qs * vz;
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      ext[i] = {{2{prod_r[i][MW-1]}}, prod_r[i]};
    end
    sum_w = -(ext[0] + ext[1] + ext[2]);
    sum_x = ext[3] - ext[4] + ext[5];
    sum_y = ext[6] - ext[7] + ext[8];
    sum_z = ext[9] - ext[10] + ext[11];
    sh_w  = sum_w >>> FRAC_BITS;
    sh_x  = sum_x >>> FRAC_BITS;
    sh_y  = sum_y >>> FRAC_BITS;
    sh_z  = sum_z >>> FRAC_BITS;
  end

  // after the shift the value fits in P_WIDTH bits
  always_ff @(posedge clk) begin
    if (en.sum) begin
      pw_r <= sh_w[P_WIDTH-1:0];
      px_r <= sh_x[P_WIDTH-1:0];
      py_r <= sh_y[P_WIDTH-1:0];
      pz_r <= sh_z[P_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- src/qvr_prod2.sv -----
// Second quaternion product p * conj(q): multiply stage, then sum, shift and saturate stage.
`timescale 1ns / 1ps
`default_nettype none
module qvr_prod2 #(
  parameter int VEC_WIDTH = qvr_pkg::QVR_VEC_WIDTH,
  parameter int FRAC_BITS = qvr_pkg::QVR_FRAC_BITS,
  parameter int P_WIDTH   = qvr_pkg::qvr_p_width(VEC_WIDTH, FRAC_BITS)
) (
  input  wire                                       clk,
  input  wire qvr_pkg::qvr_en_t                     en,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qs,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qa,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qb,
  input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0] qc,
  input  wire logic signed [P_WIDTH-1:0]            pw,
  input  wire logic signed [P_WIDTH-1:0]            px,
  input  wire logic signed [P_WIDTH-1:0]            py,
  input  wire logic signed [P_WIDTH-1:0]            pz,
  output logic signed [VEC_WIDTH-1:0]               rx_r,
  output logic signed [VEC_WIDTH-1:0]               ry_r,
  output logic signed [VEC_WIDTH-1:0]               rz_r,
  output logic                                      clip_r
);
  import qvr_pkg::*;

  localparam int MW = P_WIDTH + QUAT_WIDTH;
  localparam int SW = MW + 2;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-VEC_WIDTH+1){1'b1}}, {(VEC_WIDTH-1){1'b0}}};

  logic signed [MW-1:0] prod_r [12];
  logic signed [MW-1:0] prod_nxt [12];
  logic signed [SW-1:0] ext [12];
  logic signed [SW-1:0] sh [3];
  logic signed [VEC_WIDTH-1:0] res [3];
  logic [2:0] sat;

  always_comb begin
    prod_nxt[0]  = py * qc;
    prod_nxt[1]  = pz * qb;
    prod_nxt[2]  = pw * qa;
    prod_nxt[3]  = px * qs;
    prod_nxt[4]  = pz * qa;
    prod_nxt[5]  = px * qc;
    prod_nxt[6]  = pw * qb;
    prod_nxt[7]  = py * qs;
    prod_nxt[8]  = px * qb;
    prod_nxt[9]  = py * qa;
    prod_nxt[10] = pw * qc;
    prod_nxt[11] = pz * qs;
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      ext[i] = {{2{prod_r[i][MW-1]}}, prod_r[i]};
    end
    sh[0] = (ext[1] - ext[0] - ext[2] + ext[3]) >>> FRAC_BITS;
    sh[1] = (ext[5] - ext[4] - ext[6] + ext[7]) >>> FRAC_BITS;
    sh[2] = (ext[9] - ext[8] - ext[10] + ext[11]) >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      if (sh[i] > SAT_HI) begin
        res[i] = SAT_HI[VEC_WIDTH-1:0];
        sat[i] = 1'b1;
      end else if (sh[i] < SAT_LO) begin
        res[i] = SAT_LO[VEC_WIDTH-1:0];
        sat[i] = 1'b1;
      end else begin
        res[i] = sh[i][VEC_WIDTH-1:0];
        sat[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      rx_r   <= res[0];
      ry_r   <= res[1];
      rz_r   <= res[2];
      clip_r <= |sat;
    end
  end

endmodule
`default_nettype wire

// ----- src/quaternion_vector_rotate.sv -----
// Top level: quaternion registers, pipeline valid/stall control and the two product units.
// Four register stages (two per quaternion product, multipliers then adder tree) carry
//   each accepted item to the out_ ports; one item per cycle while out_stall is low, and
//   each stage advances under a per-stage valid and stall chain.
// Reset (synchronous, rst_n low): quaternion returns to identity (1.0, 0, 0, 0) and the
//   pipeline empties; no clearing pass, the block takes items in the first cycle after.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_vector_rotate #(
  parameter int FRAC_BITS = qvr_pkg::QVR_FRAC_BITS,
  parameter int VEC_WIDTH = qvr_pkg::QVR_VEC_WIDTH
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          cfg_we,
  input  wire logic [qvr_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
  input  wire logic [qvr_pkg::QUAT_WIDTH-1:0]          cfg_wdata,
  input  wire                                          in_valid,
  output logic                                         in_stall,
  input  wire logic signed [VEC_WIDTH-1:0]             in_x,
  input  wire logic signed [VEC_WIDTH-1:0]             in_y,
  input  wire logic signed [VEC_WIDTH-1:0]             in_z,
  output logic                                         out_valid,
  input  wire                                          out_stall,
  output logic signed [VEC_WIDTH-1:0]                  out_x,
  output logic signed [VEC_WIDTH-1:0]                  out_y,
  output logic signed [VEC_WIDTH-1:0]                  out_z,
  output logic                                         clipped
);
  import qvr_pkg::*;

  localparam int P_WIDTH = qvr_p_width(VEC_WIDTH, FRAC_BITS);

  logic signed [QUAT_WIDTH-1:0] quat_w_r, quat_x_r, quat_y_r, quat_z_r;
  logic [3:0] vld_r;
  logic [3:0] vld_nxt;
  logic [3:0] rdy;
  qvr_en_t en1, en2;
  logic signed [P_WIDTH-1:0] pw, px, py, pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_w_r <= QUAT_W_RESET;
      quat_x_r <= QUAT_V_RESET;
      quat_y_r <= QUAT_V_RESET;
      quat_z_r <= QUAT_V_RESET;
    end else if (cfg_we) begin
      case (qvr_reg_t'(cfg_index))
        REG_QUAT_W: quat_w_r <= cfg_wdata;
        REG_QUAT_X: quat_x_r <= cfg_wdata;
        REG_QUAT_Y: quat_y_r <= cfg_wdata;
        REG_QUAT_Z: quat_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or the stage after it is moving
  always_comb begin
    rdy[3] = !vld_r[3] || !out_stall;
    for (int i = 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < 4; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en1.mul   = rdy[0];
  assign en1.sum   = rdy[1];
  assign en2.mul   = rdy[2];
  assign en2.sum   = rdy[3];
  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[3];

  qvr_prod1 #(
    .VEC_WIDTH (VEC_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .P_WIDTH   (P_WIDTH)
  ) u_prod1 (
    .clk  (clk),
    .en   (en1),
    .qs   (quat_w_r),
    .qa   (quat_x_r),
    .qb   (quat_y_r),
    .qc   (quat_z_r),
    .vx   (in_x),
    .vy   (in_y),
    .vz   (in_z),
    .pw_r (pw),
    .px_r (px),
    .py_r (py),
    .pz_r (pz)
  );

  qvr_prod2 #(
    .VEC_WIDTH (VEC_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .P_WIDTH   (P_WIDTH)
  ) u_prod2 (
    .clk    (clk),
    .en     (en2),
    .qs     (quat_w_r),
    .qa     (quat_x_r),
    .qb     (quat_y_r),
    .qc     (quat_z_r),
    .pw     (pw),
    .px     (px),
    .py     (py),
    .pz     (pz),
    .rx_r   (out_x),
    .ry_r   (out_y),
    .rz_r   (out_z),
    .clip_r (clipped)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for quaternion_vector_rotate: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
  import qvr_pkg::*;

  localparam int FB          = QVR_FRAC_BITS;
  localparam int VW          = QVR_VEC_WIDTH;
  localparam int PIPE_LAT    = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;

  typedef logic signed [VW-1:0]         comp_t;
  typedef logic signed [QUAT_WIDTH-1:0] qpart_t;
  typedef struct packed { qpart_t w, x, y, z; } quat_t;
  typedef struct packed { comp_t x, y, z; logic clip; } rot_res_t;
  typedef struct packed {
    quat_t    q;
    comp_t    vx, vy, vz;
    logic     fixed;
    rot_res_t res;
  } vec_row_t;

  logic                     clk, rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [QUAT_WIDTH-1:0]    cfg_wdata;
  logic                     in_valid, in_stall;
  comp_t                    in_x, in_y, in_z;
  logic                     out_valid, out_stall;
  comp_t                    out_x, out_y, out_z;
  logic                     clipped;

  quat_t    cur_q;
  rot_res_t rot_pending[$];
  vec_row_t dir_rows[$];
  bit       calm;
  int       errors, n_sent, n_checked, n_clipped, n_settings, cycles;

  quaternion_vector_rotate DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .clipped  (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic quat_t mk_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.w = qpart_t'(w);
    q.x = qpart_t'(x);
    q.y = qpart_t'(y);
    q.z = qpart_t'(z);
    return q;
  endfunction

  function automatic comp_t sat_comp(input longint v, inout logic clip);
    longint hi, lo;
    hi = (longint'(1) <<< (VW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return comp_t'(hi);
    end
    if (v < lo) begin
      clip = 1'b1;
      return comp_t'(lo);
    end
    return comp_t'(v);
  endfunction

  // q * (0, v) * conj(q), each product floored by FB bits, final parts saturated
  function automatic rot_res_t rotate_vec(input quat_t q, input comp_t vx, input comp_t vy,
                                          input comp_t vz);
    longint   s, a, b, c, x, y, z, pw, px, py, pz, rx, ry, rz;
    logic     cl;
    rot_res_t r;
    s = $signed(q.w);
    a = $signed(q.x);
    b = $signed(q.y);
    c = $signed(q.z);
    x = $signed(vx);
    y = $signed(vy);
    z = $signed(vz);
    pw = (-(a * x + b * y + c * z)) >>> FB;
    px = (b * z - c * y + s * x) >>> FB;
    py = (c * x - a * z + s * y) >>> FB;
    pz = (a * y - b * x + s * z) >>> FB;
    rx = (-py * c + pz * b - pw * a + px * s) >>> FB;
    ry = (-pz * a + px * c - pw * b + py * s) >>> FB;
    rz = (-px * b + py * a - pw * c + pz * s) >>> FB;
    cl = 1'b0;
    r.x = sat_comp(rx, cl);
    r.y = sat_comp(ry, cl);
    r.z = sat_comp(rz, cl);
    r.clip = cl;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int extreme_int();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      4:       return 16384;
      default: return 32767;
    endcase
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0:       return comp_t'(extreme_int());
      1, 2:    return comp_t'(int'($urandom_range(0, 512)) - 256);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 40) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic add_row(input quat_t q, input int vx, input int vy, input int vz,
                         input bit fixed, input int ex, input int ey, input int ez,
                         input bit ec);
    vec_row_t r;
    r.q     = q;
    r.vx    = comp_t'(vx);
    r.vy    = comp_t'(vy);
    r.vz    = comp_t'(vz);
    r.fixed = fixed;
    r.res.x = comp_t'(ex);
    r.res.y = comp_t'(ey);
    r.res.z = comp_t'(ez);
    r.res.clip = ec;
    dir_rows.push_back(r);
  endtask

  // only the registers that change are written
  task automatic load_quat(input quat_t q);
    qpart_t part;
    bit     diff;
    for (int i = 0; i < 4; i++) begin
      case (qvr_reg_t'(i))
        REG_QUAT_W: begin part = q.w; diff = (q.w != cur_q.w); end
        REG_QUAT_X: begin part = q.x; diff = (q.x != cur_q.x); end
        REG_QUAT_Y: begin part = q.y; diff = (q.y != cur_q.y); end
        REG_QUAT_Z: begin part = q.z; diff = (q.z != cur_q.z); end
        default:    begin part = '0; diff = 1'b0; end
      endcase
      if (diff) begin
        cfg_we    <= 1'b1;
        cfg_index <= qvr_reg_t'(i);
        cfg_wdata <= part;
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    cur_q = q;
    n_settings++;
  endtask

  task automatic send_vec(input comp_t x, input comp_t y, input comp_t z, input rot_res_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    rot_pending.push_back(want);
    n_sent++;
  endtask

  task automatic drain_pipe();
    @(posedge clk);
    while (rot_pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int run;
    forever begin
      run = calm ? 50 : $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      run = pick_gap();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rot_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rot_pending.size() == 0) begin
        report($sformatf("result (%0d,%0d,%0d) with nothing outstanding", out_x, out_y, out_z));
      end else begin
        want = rot_pending.pop_front();
        n_checked++;
        if (clipped) n_clipped++;
        if (out_x !== want.x) report($sformatf("out_x %0d, want %0d", out_x, want.x));
        if (out_y !== want.y) report($sformatf("out_y %0d, want %0d", out_y, want.y));
        if (out_z !== want.z) report($sformatf("out_z %0d, want %0d", out_z, want.z));
        if (clipped !== want.clip) report($sformatf("clipped %b, want %b", clipped, want.clip));
      end
    end
  end

  initial begin
    quat_t    q_id, q_half, q_neg2, q_flipx, q_rotz, q_zero, q_max, q_min, q_mix, nq;
    vec_row_t row;
    rot_res_t want;
    comp_t    x, y, z;
    int       axis, mag;
    bit       half;

    calm      = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_QUAT_W;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_x      <= '0;
    in_y      <= '0;
    in_z      <= '0;
    cur_q = mk_quat(QUAT_W_RESET, QUAT_V_RESET, QUAT_V_RESET, QUAT_V_RESET);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    q_id    = mk_quat(16384, 0, 0, 0);
    q_half  = mk_quat(8192, 0, 0, 0);
    q_neg2  = mk_quat(-32768, 0, 0, 0);
    q_flipx = mk_quat(0, 16384, 0, 0);
    q_rotz  = mk_quat(11585, 0, 0, 11585);
    q_zero  = mk_quat(0, 0, 0, 0);
    q_max   = mk_quat(32767, 32767, 32767, 32767);
    q_min   = mk_quat(-32768, -32768, -32768, -32768);
    q_mix   = mk_quat(-1, 32767, -32768, 1);

    // identity straight out of reset
    add_row(q_id, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(q_id, 32767, -32768, 0, 1, 32767, -32768, 0, 0);
    add_row(q_id, -32768, 32767, -1, 1, -32768, 32767, -1, 0);
    add_row(q_id, 1, -1, 12345, 1, 1, -1, 12345, 0);
    add_row(q_id, -21846, -1, -32768, 0, 0, 0, 0, 0);
    // half scale: both shifts floor towards minus infinity
    add_row(q_half, 1, -1, 3, 1, 0, -1, 0, 0);
    add_row(q_half, -32768, 32767, 2, 1, -8192, 8191, 0, 0);
    // w = -2.0 scales by four, saturating at the rails
    add_row(q_neg2, 1, -1, 0, 1, 4, -4, 0, 0);
    add_row(q_neg2, 32767, 0, 0, 1, 32767, 0, 0, 1);
    add_row(q_neg2, -32768, -32768, -32768, 1, -32768, -32768, -32768, 1);
    add_row(q_neg2, 8191, -8192, 0, 1, 32764, -32768, 0, 0);
    // half turn about x: negating -32768 clips
    add_row(q_flipx, 5, -32768, 7, 1, 5, 32767, -7, 1);
    add_row(q_flipx, -32768, 1, 32767, 1, -32768, -1, -32767, 0);
    add_row(q_rotz, 10000, 0, 0, 0, 0, 0, 0, 0);
    add_row(q_rotz, 32767, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(q_rotz, -32768, -32768, -32768, 0, 0, 0, 0, 0);
    add_row(q_zero, 32767, -32768, -1, 1, 0, 0, 0, 0);
    add_row(q_max, 32767, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(q_max, -32768, 12345, 1, 0, 0, 0, 0, 0);
    add_row(q_min, 1, 1, 1, 0, 0, 0, 0, 0);
    add_row(q_min, -32768, 32767, 0, 0, 0, 0, 0, 0);
    add_row(q_mix, -1, -1, -1, 0, 0, 0, 0, 0);
    add_row(q_mix, 21845, -21846, 0, 0, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.q != cur_q) begin
        in_valid <= 1'b0;
        drain_pipe();
        load_quat(row.q);
      end
      want = row.fixed ? row.res : rotate_vec(cur_q, row.vx, row.vy, row.vz);
      send_vec(row.vx, row.vy, row.vz, want);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: nq = mk_quat($urandom, $urandom, $urandom, $urandom);
        1: nq = mk_quat(int'($urandom_range(0, 32768)) - 16384,
                        int'($urandom_range(0, 32768)) - 16384,
                        int'($urandom_range(0, 32768)) - 16384,
                        int'($urandom_range(0, 32768)) - 16384);
        2: begin
          // quarter or half turn about one axis
          axis = $urandom_range(1, 3);
          half = 1'($urandom_range(0, 1));
          mag  = half ? 11585 : 16384;
          if ($urandom_range(0, 1)) mag = -mag;
          nq = mk_quat(half ? 11585 : 0, axis == 1 ? mag : 0, axis == 2 ? mag : 0,
                       axis == 3 ? mag : 0);
        end
        default: nq = mk_quat(extreme_int(), extreme_int(), extreme_int(), extreme_int());
      endcase
      drain_pipe();
      calm = (p == 2 || p == 5);
      load_quat(nq);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        x = rand_comp();
        y = rand_comp();
        z = rand_comp();
        send_vec(x, y, z, rotate_vec(cur_q, x, y, z));
      end
      in_valid <= 1'b0;
    end

    calm = 1'b0;
    drain_pipe();
    $display("Summary: %0d vectors sent under %0d quaternion settings.", n_sent, n_settings);
    $display("Summary: %0d results compared, %0d of them saturated.", n_checked, n_clipped);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
